@@ rtl/ultrasonic_ranging_sequencer_defines.svh @@
// ----------------------------------------------------------------------------
// Ultrasonic ranging sequencer assertion macros
// Shared property wrappers for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef ULTRASONIC_RANGING_SEQUENCER_DEFINES_SVH
`define ULTRASONIC_RANGING_SEQUENCER_DEFINES_SVH

// Same-cycle implication, sampled on i_clk, off while i_rst_n is low
`define URS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off while i_rst_n is low
`define URS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/urs_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ultrasonic ranging sequencer package
// Shared codes, constants and controller/datapath interface types.
// ----------------------------------------------------------------------------
package urs_pkg;

    // Event codes on the result beat
    localparam logic [1:0] EV_NONE = 2'd0;
    localparam logic [1:0] EV_MEAS = 2'd1;
    localparam logic [1:0] EV_TOUT = 2'd2;

    // Configuration register indexes
    localparam logic [2:0] CFG_TICKS_PER_US  = 3'd0;
    localparam logic [2:0] CFG_TRIG_PULSE_US = 3'd1;
    localparam logic [2:0] CFG_START_TOUT_US = 3'd2;
    localparam logic [2:0] CFG_ECHO_TOUT_US  = 3'd3;
    localparam logic [2:0] CFG_PERIOD_MS     = 3'd4;

    // Configuration reset values
    localparam logic [7:0]  RST_TICKS_PER_US  = 8'd3;
    localparam logic [15:0] RST_TRIG_PULSE_US = 16'd10;
    localparam logic [15:0] RST_START_TOUT_US = 16'd5000;
    localparam logic [15:0] RST_ECHO_TOUT_US  = 16'd30000;
    localparam logic [15:0] RST_PERIOD_MS     = 16'd30;

    // Distance = (us*10 + 29) / 58; at or above this many us the result tops 16 bits
    localparam logic [31:0] MM_SAT_US  = 32'd380106;
    localparam logic [22:0] MM_ROUND   = 23'd29;
    // x / 58 equals (x * MM_RECIP) >> MM_SHIFT for every x below 2^23
    localparam logic [22:0] MM_RECIP   = 23'd4628198;
    localparam int unsigned MM_SHIFT   = 28;
    localparam logic [15:0] MM_MAX     = 16'hFFFF;

    // Stream widths
    localparam int unsigned IN_W   = 72;
    localparam int unsigned OUT_W  = 56;
    localparam int unsigned USER_W = 8;

    typedef struct packed {
        logic load;        // latch the input beat
        logic div_start;   // launch the tick divider
        logic cap_us;      // keep the elapsed-us quotient and its scaled form
        logic cap_mm;      // keep the distance from the reciprocal multiply
        logic commit;      // update state and load the result register
    } t_cmd;

    typedef struct packed {
        logic need_us;
        logic need_mm;
        logic div_done;
        logic out_free;
    } t_sts;

endpackage

@@ rtl/urs_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ultrasonic ranging sequencer divider
// Restoring divider, 32-bit dividend by 8-bit divisor, one bit per cycle.
// ----------------------------------------------------------------------------
module urs_div import urs_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_dividend,
    input  logic [7:0]  i_divisor,
    output logic        o_done,
    output logic [31:0] o_quot
);

    logic        r_busy;
    logic        r_done;
    logic [4:0]  r_cnt;
    logic [31:0] r_q;
    logic [7:0]  r_rem;
    logic [7:0]  r_dvs;
    logic [8:0]  rem_sh;
    logic [8:0]  diff;
    logic        ge;

    assign rem_sh = {r_rem, r_q[31]};
    assign ge     = rem_sh >= {1'b0, r_dvs};
    assign diff   = rem_sh - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_q   <= {r_q[30:0], ge};
            r_rem <= ge ? diff[7:0] : rem_sh[7:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

@@ rtl/urs_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ultrasonic ranging sequencer datapath
// Ranging state, configuration registers, tick divider and result register.
// ----------------------------------------------------------------------------
module urs_dp import urs_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cmd                i_cmd,
    output t_sts                o_sts,
    input  logic [IN_W-1:0]     i_in_data,
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_index,
    input  logic [15:0]         i_cfg_data,
    output logic                o_m_valid,
    input  logic                i_m_ready,
    output logic [OUT_W-1:0]    o_m_data,
    output logic [USER_W-1:0]   o_m_user
);

    typedef enum logic [1:0] {PH_IDLE, PH_TRIG, PH_RISE, PH_FALL} t_phase;

    // configuration
    logic [7:0]  r_tpu;
    logic [15:0] r_pulse;
    logic [15:0] r_start_to;
    logic [15:0] r_echo_to;
    logic [15:0] r_period;

    // ranging state
    t_phase      r_phase,  n_phase;
    logic        r_side,   n_side;
    logic [31:0] r_pst,    n_pst;
    logic [31:0] r_erise,  n_erise;
    logic [31:0] r_due [2];
    logic [31:0] n_due [2];
    logic [15:0] r_held_l, n_held_l;
    logic [15:0] r_held_r, n_held_r;
    logic [1:0]  r_vld,    n_vld;
    logic [1:0]  r_tout,   n_tout;

    // latched poll
    logic [31:0] r_now;
    logic [31:0] r_tick;
    logic [1:0]  r_echo;
    logic [31:0] r_us;
    logic [22:0] r_scaled;
    logic [15:0] r_quot_mm;

    // result register
    logic              r_m_valid;
    logic [OUT_W-1:0]  r_m_data;
    logic [USER_W-1:0] r_m_user;

    logic        echo_s;
    logic        sat;
    logic [31:0] div_dvd;
    logic [7:0]  div_dvs;
    logic        div_done;
    logic [31:0] div_q;
    logic [22:0] scaled;
    logic [45:0] mm_prod;
    logic [1:0]  ev;
    logic [15:0] meas_mm;
    logic        trig_n;

    assign echo_s = r_echo[r_side];
    assign sat    = r_us >= MM_SAT_US;

    // us*10 + 29; only used below the saturation point, where us fits 19 bits
    assign scaled  = {1'b0, div_q[18:0], 3'b000} + {3'b000, div_q[18:0], 1'b0} + MM_ROUND;
    assign mm_prod = 46'(r_scaled) * 46'(MM_RECIP);

    assign div_dvd = ((r_phase == PH_FALL && !echo_s) ? r_erise : r_pst) - r_tick;
    assign div_dvs = (r_tpu == 8'd0) ? 8'd1 : r_tpu;

    urs_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (div_dvd),
        .i_divisor  (div_dvs),
        .o_done     (div_done),
        .o_quot     (div_q)
    );

    always_comb begin
        o_sts.need_us  = (r_phase == PH_TRIG) || (r_phase == PH_FALL)
                         || (r_phase == PH_RISE && !echo_s);
        o_sts.need_mm  = (r_phase == PH_FALL) && !echo_s && !sat;
        o_sts.div_done = div_done;
        o_sts.out_free = !r_m_valid || i_m_ready;
    end

    // next ranging state for the latched poll
    always_comb begin
        n_phase  = r_phase;
        n_side   = r_side;
        n_pst    = r_pst;
        n_erise  = r_erise;
        n_due    = r_due;
        n_held_l = r_held_l;
        n_held_r = r_held_r;
        n_vld    = r_vld;
        n_tout   = r_tout;
        ev       = EV_NONE;
        meas_mm  = '0;
        case (r_phase)
            PH_IDLE: begin
                if (r_now >= r_due[0]) begin
                    n_side  = 1'b0;
                    n_pst   = r_tick;
                    n_phase = PH_TRIG;
                end else if (r_now >= r_due[1]) begin
                    n_side  = 1'b1;
                    n_pst   = r_tick;
                    n_phase = PH_TRIG;
                end
            end
            PH_TRIG: begin
                if (r_us >= {16'd0, r_pulse}) begin
                    n_pst   = r_tick;
                    n_phase = PH_RISE;
                end
            end
            PH_RISE: begin
                if (echo_s) begin
                    n_erise = r_tick;
                    n_pst   = r_tick;
                    n_phase = PH_FALL;
                end else if (r_us > {16'd0, r_start_to}) begin
                    ev = EV_TOUT;
                end
            end
            default: begin
                if (!echo_s) begin
                    ev      = EV_MEAS;
                    meas_mm = sat ? MM_MAX : r_quot_mm;
                end else if (r_us > {16'd0, r_echo_to}) begin
                    ev = EV_TOUT;
                end
            end
        endcase
        if (ev == EV_MEAS) begin
            if (r_side) begin
                n_held_r = meas_mm;
            end else begin
                n_held_l = meas_mm;
            end
            n_vld[r_side]  = 1'b1;
            n_tout[r_side] = 1'b0;
        end else if (ev == EV_TOUT) begin
            n_vld[r_side]  = 1'b0;
            n_tout[r_side] = 1'b1;
        end
        if (ev != EV_NONE) begin
            n_due[r_side] = r_now + {15'd0, r_period, 1'b0};
            n_phase       = PH_IDLE;
        end
        trig_n = (n_phase == PH_TRIG);
    end

    // control and architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tpu      <= RST_TICKS_PER_US;
            r_pulse    <= RST_TRIG_PULSE_US;
            r_start_to <= RST_START_TOUT_US;
            r_echo_to  <= RST_ECHO_TOUT_US;
            r_period   <= RST_PERIOD_MS;
            r_phase    <= PH_IDLE;
            r_side     <= 1'b0;
            r_pst      <= '0;
            r_erise    <= '0;
            r_due[0]   <= '0;
            r_due[1]   <= {16'd0, RST_PERIOD_MS};
            r_held_l   <= '0;
            r_held_r   <= '0;
            r_vld      <= '0;
            r_tout     <= '0;
            r_m_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_TICKS_PER_US:  r_tpu      <= i_cfg_data[7:0];
                    CFG_TRIG_PULSE_US: r_pulse    <= i_cfg_data;
                    CFG_START_TOUT_US: r_start_to <= i_cfg_data;
                    CFG_ECHO_TOUT_US:  r_echo_to  <= i_cfg_data;
                    CFG_PERIOD_MS:     r_period   <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.commit) begin
                r_phase   <= n_phase;
                r_side    <= n_side;
                r_pst     <= n_pst;
                r_erise   <= n_erise;
                r_due     <= n_due;
                r_held_l  <= n_held_l;
                r_held_r  <= n_held_r;
                r_vld     <= n_vld;
                r_tout    <= n_tout;
                r_m_valid <= 1'b1;
            end else if (i_m_ready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_now  <= i_in_data[31:0];
            r_tick <= i_in_data[63:32];
            r_echo <= i_in_data[65:64];
        end
        if (i_cmd.cap_us) begin
            r_us     <= div_q;
            r_scaled <= scaled;
        end
        if (i_cmd.cap_mm) begin
            r_quot_mm <= mm_prod[MM_SHIFT+15:MM_SHIFT];
        end
        if (i_cmd.commit) begin
            r_m_data <= {2'd0, n_tout[1], n_tout[0], n_vld[1], n_vld[0],
                         n_held_r, n_held_l, meas_mm,
                         trig_n && n_side, trig_n && !n_side};
            r_m_user <= {5'd0, (ev != EV_NONE) && r_side, ev};
        end
    end

    assign o_m_valid = r_m_valid;
    assign o_m_data  = r_m_data;
    assign o_m_user  = r_m_user;

endmodule

@@ rtl/urs_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ultrasonic ranging sequencer controller
// Steps one poll through latch, divide, commit and result hand-off.
// ----------------------------------------------------------------------------
module urs_ctrl import urs_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE, S_DECIDE, S_WAIT_US, S_CHK, S_DONE
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (i_sts.need_us) begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_WAIT_US;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_WAIT_US: begin
                if (i_sts.div_done) begin
                    o_cmd.cap_us = 1'b1;
                    n_state      = S_CHK;
                end
            end
            S_CHK: begin
                // reciprocal multiply for the divide by 58
                if (i_sts.need_mm) begin
                    o_cmd.cap_mm = 1'b1;
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

@@ rtl/ultrasonic_ranging_sequencer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ultrasonic ranging sequencer
// Two-ranger trigger/echo sequencer with an iterative tick divider.
// ----------------------------------------------------------------------------
// Usage:
//  - Slave stream: one beat per poll (time in ms, tick timer count, both echo
//    pins). Master stream: exactly one result beat per poll with trigger
//    levels, event code and side in tuser, and the held distances and flags.
//  - Config channel: write register index and data at any idle moment; it is
//    always ready and takes effect for the next poll.
//  - Sequence: an accepted poll goes from its decide step to the result
//    when no timing is needed (idle polls, echo-rise polls). When elapsed
//    time is checked, a distance included, the 32-step tick divider runs
//    first; the divide by 58 is a reciprocal multiply in the cycle after it.
//  - Flow: one poll at a time; a poll holds the block until its result is
//    loaded, and the next beat is taken in the cycle after that load.
//  - Reset: config returns to its defaults, sequencer idles with left due at
//    once and right due at 30 ms, held readings and flags clear.
//  - Stall: a waiting result holds; a finished poll waits for the output slot
//    before it updates state, so no beat is dropped.
// ----------------------------------------------------------------------------
module ultrasonic_ranging_sequencer import urs_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // poll stream
    input  logic              i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    // [31:0] now_ms, [63:32] timer_count, [64] echo_left, [65] echo_right
    input  logic [IN_W-1:0]   i_s_axis_tdata,
    // result stream
    output logic              o_m_axis_tvalid,
    input  logic              i_m_axis_tready,
    // [0] trig_left, [1] trig_right, [17:2] distance_mm, [33:18] held left mm,
    // [49:34] held right mm, [50] left ok, [51] right ok,
    // [52] left_timeout, [53] right_timeout
    output logic [OUT_W-1:0]  o_m_axis_tdata,
    // [1:0] event_res, [2] event_side
    output logic [USER_W-1:0] o_m_axis_tuser,
    // config write channel
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [2:0]        i_cfg_index,
    input  logic [15:0]       i_cfg_data
);

    t_cmd cmd;
    t_sts sts;

    // config writes are direct register loads
    assign o_cfg_ready = 1'b1;

    urs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    urs_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_in_data   (i_s_axis_tdata),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_m_valid   (o_m_axis_tvalid),
        .i_m_ready   (i_m_axis_tready),
        .o_m_data    (o_m_axis_tdata),
        .o_m_user    (o_m_axis_tuser)
    );

endmodule

@@ rtl/urs_chk.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ultrasonic ranging sequencer checker
// Port-level properties of the result stream, bound to the top level.
// ----------------------------------------------------------------------------
`include "ultrasonic_ranging_sequencer_defines.svh"

module urs_chk import urs_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              o_m_axis_tvalid,
    input  logic              i_m_axis_tready,
    input  logic [OUT_W-1:0]  o_m_axis_tdata,
    input  logic [USER_W-1:0] o_m_axis_tuser
);

    logic                     trig_l;
    logic                     trig_r;
    logic [1:0]               ev_code;
    logic [15:0]              meas_mm;
    logic [15:0]              held_l_mm;
    logic [3:0]               flags;      // left ok, right ok, left tout, right tout
    logic                     meas_left;
    logic                     beat_stall;
    logic [OUT_W+USER_W-1:0]  beat_word;

    assign trig_l     = o_m_axis_tdata[0];
    assign trig_r     = o_m_axis_tdata[1];
    assign ev_code    = o_m_axis_tuser[1:0];
    assign meas_mm    = o_m_axis_tdata[17:2];
    assign held_l_mm  = o_m_axis_tdata[33:18];
    assign flags      = o_m_axis_tdata[53:50];
    assign meas_left  = o_m_axis_tvalid && (ev_code == EV_MEAS) && !o_m_axis_tuser[2];
    assign beat_stall = o_m_axis_tvalid && !i_m_axis_tready;
    assign beat_word  = {o_m_axis_tuser, o_m_axis_tdata};

    // only one ranger fires at a time
    `URS_ASSERT_IMP(a_one_trigger, o_m_axis_tvalid, !(trig_l && trig_r), "both triggers high")

    // a side never reads valid and timed out together
    `URS_ASSERT_IMP(a_flags_excl, o_m_axis_tvalid, (flags[1:0] & flags[3:2]) == 2'b00, "ok and timeout")

    // distance field carries data only on a measurement
    `URS_ASSERT_IMP(a_dist_zero, o_m_axis_tvalid && (ev_code != EV_MEAS), meas_mm == 16'd0, "stray mm")

    // a left measurement is held and flagged valid in the same beat
    `URS_ASSERT_IMP(a_left_hold, meas_left, flags[0] && (held_l_mm == meas_mm), "left not held")

    // a stalled result beat holds
    `URS_ASSERT_NXT(a_out_hold, beat_stall, o_m_axis_tvalid && $stable(beat_word), "beat changed")

endmodule

bind ultrasonic_ranging_sequencer urs_chk u_urs_chk (.*);

@@ tb/ultrasonic_ranging_sequencer_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ultrasonic ranging sequencer testbench
// Drives poll beats that play out trigger/echo sequences for both rangers,
// with timer wrap, saturated distances, timeouts and noise. A scoreboard
// keeps its own copy of the sequencer state and registers, predicts one
// result per poll and checks every result beat field by field. The run
// steps through several register settings and several idling patterns.
// ----------------------------------------------------------------------------
module ultrasonic_ranging_sequencer_test;
    import urs_pkg::*;

    localparam int unsigned IDLE_LIMIT   = 4000;  // cycles without any beat
    localparam int unsigned N_PHASES     = 8;
    localparam int unsigned PHASE_POLLS  = 153;

    // sequencer phases as the scoreboard tracks them
    typedef enum logic [1:0] {
        SEQ_IDLE = 2'd0,
        SEQ_TRIG = 2'd1,
        SEQ_RISE = 2'd2,
        SEQ_FALL = 2'd3
    } t_seq_phase;

    typedef struct {
        bit        trig_left;
        bit        trig_right;
        bit [1:0]  event_res;
        bit        event_side;
        bit [15:0] distance_mm;
        bit [15:0] l_held_mm;
        bit [15:0] r_held_mm;
        bit        l_ok;
        bit        r_ok;
        bit        left_timeout;
        bit        right_timeout;
    } t_ranging_beat;

    // ------------------------------------------------------------------------
    // Scoreboard: private copy of registers and sequencer state
    // ------------------------------------------------------------------------
    class t_ranging_scoreboard;
        bit [7:0]      ticks_per_us;
        bit [15:0]     pulse_us;
        bit [15:0]     rise_limit_us;
        bit [15:0]     echo_limit_us;
        bit [15:0]     period_ms;
        t_seq_phase    phase;
        bit            side;
        bit [31:0]     phase_tick;
        bit [31:0]     rise_tick;
        bit [31:0]     due_ms [2];
        bit [15:0]     held_mm [2];
        bit [1:0]      valid_flags;
        bit [1:0]      tout_flags;
        t_ranging_beat pending [$];
        int unsigned   errors, polls, results, writes;
        int unsigned   n_meas, n_tout, n_sat;

        function new();
            ticks_per_us  = RST_TICKS_PER_US;
            pulse_us      = RST_TRIG_PULSE_US;
            rise_limit_us = RST_START_TOUT_US;
            echo_limit_us = RST_ECHO_TOUT_US;
            period_ms     = RST_PERIOD_MS;
            phase         = SEQ_IDLE;
            side          = 1'b0;
            phase_tick    = '0;
            rise_tick     = '0;
            due_ms[0]     = '0;
            due_ms[1]     = 32'(RST_PERIOD_MS);
            held_mm[0]    = '0;
            held_mm[1]    = '0;
            valid_flags   = '0;
            tout_flags    = '0;
        endfunction

        function void write_reg(bit [2:0] index, bit [15:0] value);
            writes++;
            case (index)
                CFG_TICKS_PER_US:  ticks_per_us  = value[7:0];
                CFG_TRIG_PULSE_US: pulse_us      = value;
                CFG_START_TOUT_US: rise_limit_us = value;
                CFG_ECHO_TOUT_US:  echo_limit_us = value;
                CFG_PERIOD_MS:     period_ms     = value;
                default: ;
            endcase
        endfunction

        // divisor of zero counts as one; tick difference wraps mod 2^32
        function bit [31:0] elapsed_us(bit [31:0] start_tick, bit [31:0] cur_tick);
            bit [31:0] div;
            div = (ticks_per_us == 8'd0) ? 32'd1 : 32'(ticks_per_us);
            return (start_tick - cur_tick) / div;
        endfunction

        // work out the result of one accepted poll and queue it
        function void note_poll(bit [31:0] now_ms, bit [31:0] tick, bit echo_l, bit echo_r);
            t_ranging_beat beat;
            bit [1:0]  ev;
            bit [15:0] meas_mm;
            bit        echo_on;
            bit [63:0] mm;
            ev      = EV_NONE;
            meas_mm = '0;
            echo_on = side ? echo_r : echo_l;
            polls++;
            case (phase)
                SEQ_IDLE: begin
                    if (now_ms >= due_ms[0] || now_ms >= due_ms[1]) begin
                        side       = (now_ms >= due_ms[0]) ? 1'b0 : 1'b1;
                        phase_tick = tick;
                        phase      = SEQ_TRIG;
                    end
                end
                SEQ_TRIG: begin
                    if (elapsed_us(phase_tick, tick) >= 32'(pulse_us)) begin
                        phase_tick = tick;
                        phase      = SEQ_RISE;
                    end
                end
                SEQ_RISE: begin
                    if (echo_on) begin
                        rise_tick  = tick;
                        phase_tick = tick;
                        phase      = SEQ_FALL;
                    end else if (elapsed_us(phase_tick, tick) > 32'(rise_limit_us)) begin
                        ev = EV_TOUT;
                    end
                end
                default: begin
                    if (!echo_on) begin
                        mm = (64'(elapsed_us(rise_tick, tick)) * 64'd10 + 64'd29) / 64'd58;
                        if (mm > 64'(MM_MAX)) begin
                            mm = 64'(MM_MAX);
                            n_sat++;
                        end
                        meas_mm = mm[15:0];
                        ev      = EV_MEAS;
                    end else if (elapsed_us(phase_tick, tick) > 32'(echo_limit_us)) begin
                        ev = EV_TOUT;
                    end
                end
            endcase

            if (ev != EV_NONE) begin
                if (ev == EV_MEAS) begin
                    held_mm[side]     = meas_mm;
                    valid_flags[side] = 1'b1;
                    tout_flags[side]  = 1'b0;
                    n_meas++;
                end else begin
                    valid_flags[side] = 1'b0;
                    tout_flags[side]  = 1'b1;
                    n_tout++;
                end
                due_ms[side] = now_ms + 32'(period_ms) * 32'd2;
                phase        = SEQ_IDLE;
            end

            beat.trig_left     = (phase == SEQ_TRIG) && !side;
            beat.trig_right    = (phase == SEQ_TRIG) && side;
            beat.event_res     = ev;
            beat.event_side    = (ev != EV_NONE) ? side : 1'b0;
            beat.distance_mm   = meas_mm;
            beat.l_held_mm     = held_mm[0];
            beat.r_held_mm     = held_mm[1];
            beat.l_ok          = valid_flags[0];
            beat.r_ok          = valid_flags[1];
            beat.left_timeout  = tout_flags[0];
            beat.right_timeout = tout_flags[1];
            pending.push_back(beat);
        endfunction

        function void report(string what, bit [15:0] want, bit [15:0] got);
            errors++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
        endfunction

        function void cmp(string what, bit [15:0] want, bit [15:0] got);
            if (want != got) report(what, want, got);
        endfunction

        // compare one accepted result beat against the oldest prediction
        function void check_result(logic [OUT_W-1:0] data, logic [USER_W-1:0] user);
            t_ranging_beat want;
            results++;
            if (pending.size() == 0) begin
                errors++;
                $display("%0t: result beat with nothing expected, expected none, actual %0h/%0h",
                         $time, data, user);
                return;
            end
            want = pending.pop_front();
            cmp("trig_left",      16'(want.trig_left),     16'(data[0]));
            cmp("trig_right",     16'(want.trig_right),    16'(data[1]));
            cmp("distance_mm",    want.distance_mm,        data[17:2]);
            cmp("held left mm",   want.l_held_mm,          data[33:18]);
            cmp("held right mm",  want.r_held_mm,          data[49:34]);
            cmp("left ok",        16'(want.l_ok),          16'(data[50]));
            cmp("right ok",       16'(want.r_ok),          16'(data[51]));
            cmp("left_timeout",   16'(want.left_timeout),  16'(data[52]));
            cmp("right_timeout",  16'(want.right_timeout), 16'(data[53]));
            cmp("event_res",      16'(want.event_res),     16'(user[1:0]));
            cmp("event_side",     16'(want.event_side),    16'(user[2]));
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, DUT connections and shared testbench state
    // ------------------------------------------------------------------------
    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              poll_valid = 1'b0;
    logic              poll_ready;
    logic [IN_W-1:0]   poll_data = '0;
    logic              res_valid;
    logic              res_ready = 1'b0;
    logic [OUT_W-1:0]  res_data;
    logic [USER_W-1:0] res_user;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [2:0]        cfg_index = '0;
    logic [15:0]       cfg_data = '0;

    t_ranging_scoreboard sb = new();
    int unsigned       send_idle_pct  = 0;
    int unsigned       recv_stall_pct = 0;
    int unsigned       idle_cycles    = 0;
    bit [31:0]         env_ms   = '0;   // time the simulated rangers live in
    bit [31:0]         env_tick = '0;

    always #5 i_clk = ~i_clk;

    ultrasonic_ranging_sequencer u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (poll_valid),
        .o_s_axis_tready (poll_ready),
        .i_s_axis_tdata  (poll_data),
        .o_m_axis_tvalid (res_valid),
        .i_m_axis_tready (res_ready),
        .o_m_axis_tdata  (res_data),
        .o_m_axis_tuser  (res_user),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    // Stall the result side at random; the stall rate follows the phase.
    always @(negedge i_clk) begin
        res_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Sample every handshake at the rising edge: check results first, then
    // note the poll, so a result and the next poll in one cycle line up.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (res_valid && res_ready) begin
                sb.check_result(res_data, res_user);
            end
            if (poll_valid && poll_ready) begin
                sb.note_poll(poll_data[31:0], poll_data[63:32], poll_data[64], poll_data[65]);
            end
            if (cfg_valid && cfg_ready) begin
                sb.write_reg(cfg_index, cfg_data);
            end
            if ((res_valid && res_ready) || (poll_valid && poll_ready) ||
                (cfg_valid && cfg_ready)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            // watchdog: nothing moved for far longer than the slowest poll
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: no beat for %0d cycles, %0d results outstanding",
                         $time, idle_cycles, sb.pending.size());
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Driver tasks; each starts and ends at a falling edge
    // ------------------------------------------------------------------------

    // Drop valid for a random gap; with drain set, hold off until every
    // predicted result has come back.
    task automatic hold_poll(input bit drain);
        if (drain || $urandom_range(0, 99) < send_idle_pct) begin
            poll_valid <= 1'b0;
            do @(negedge i_clk);
            while ((drain && sb.pending.size() != 0) || $urandom_range(0, 99) < send_idle_pct);
        end
    endtask

    task automatic drive_poll(input bit [31:0] now_ms, input bit [31:0] tick,
                              input bit echo_l, input bit echo_r);
        poll_valid <= 1'b1;
        poll_data  <= {6'b0, echo_r, echo_l, tick, now_ms};
        do @(posedge i_clk); while (!poll_ready);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] index, input logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do @(posedge i_clk); while (!cfg_ready);
        @(negedge i_clk);
    endtask

    // Build the next poll from where the sequencer stands: advance time and
    // the down-counting timer, and play the echo of the active side so that
    // rises, falls and both timeouts all happen. Noise polls jump anywhere.
    task automatic random_poll();
        bit [31:0] tpu, span, low_due;
        bit        echo_l, echo_r, echo_act;
        tpu      = (sb.ticks_per_us == 8'd0) ? 32'd1 : 32'(sb.ticks_per_us);
        echo_l   = $urandom_range(0, 1);
        echo_r   = $urandom_range(0, 1);
        echo_act = $urandom_range(0, 1);
        span     = tpu * 32'd8;
        if ($urandom_range(0, 9) == 0) begin
            env_ms   = $urandom;
            env_tick = $urandom;
        end else begin
            case (sb.phase)
                SEQ_IDLE: begin
                    low_due = (sb.due_ms[0] < sb.due_ms[1]) ? sb.due_ms[0] : sb.due_ms[1];
                    // jump to the next due time half of the time
                    if (env_ms < low_due && $urandom_range(0, 1) == 1) begin
                        env_ms = low_due + $urandom_range(0, 2);
                    end else begin
                        env_ms = env_ms + $urandom_range(0, 3);
                    end
                end
                SEQ_TRIG: begin
                    span     = tpu * 32'(sb.pulse_us) / 32'd2 + 32'd2;
                    echo_act = ($urandom_range(0, 7) == 0);
                end
                SEQ_RISE: begin
                    span     = tpu * 32'(sb.rise_limit_us) / 32'd3 + 32'd2;
                    echo_act = ($urandom_range(0, 3) == 0);
                    env_ms   = env_ms + $urandom_range(0, 1);
                end
                default: begin
                    span     = tpu * 32'(sb.echo_limit_us) / 32'd4 + 32'd2;
                    echo_act = ($urandom_range(0, 2) != 0);
                    env_ms   = env_ms + $urandom_range(0, 1);
                    // now and then a huge echo, to saturate the distance
                    if ($urandom_range(0, 39) == 0) span = 32'hFFFF_FFFF;
                end
            endcase
            env_tick = env_tick - $urandom_range(0, span);
            if (sb.phase != SEQ_IDLE) begin
                if (sb.side) echo_r = echo_act;
                else         echo_l = echo_act;
            end
        end
        drive_poll(env_ms, env_tick, echo_l, echo_r);
    endtask

    // Register settings per phase: reset values first, then the lower and
    // upper extremes, a zero divisor, and random mixes after that.
    task automatic apply_settings(input int unsigned k);
        logic [7:0]  tpu;
        logic [15:0] pulse, rise_lim, echo_lim, period;
        tpu      = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                               : 8'($urandom_range(1, 8));
        pulse    = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 50));
        rise_lim = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 400));
        echo_lim = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 2000));
        period   = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 40));
        case (k)
            1: begin
                tpu = 8'd1; pulse = '0; rise_lim = '0; echo_lim = '0; period = '0;
            end
            2: begin
                tpu = 8'hFF; pulse = '1; rise_lim = '1; echo_lim = '1; period = '1;
            end
            3: tpu = 8'd0;
            default: ;
        endcase
        write_reg(CFG_TICKS_PER_US, {8'b0, tpu});
        write_reg(CFG_TRIG_PULSE_US, pulse);
        write_reg(CFG_START_TOUT_US, rise_lim);
        write_reg(CFG_ECHO_TOUT_US, echo_lim);
        write_reg(CFG_PERIOD_MS, period);
        // an unused index must leave every register alone
        if (k >= 4) begin
            write_reg(CFG_PERIOD_MS + 3'($urandom_range(1, 3)), 16'($urandom));
        end
        cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed sequences at reset settings, no idling: timer wrap in the
        // trigger pulse, an ignored far-side echo, a plain measurement, a
        // start timeout, a saturated distance, an echo timeout, and a
        // measurement at the top of the ms range so the due time wraps.
        drive_poll(32'd0, 32'h0000_0010, 1'b0, 1'b0);
        drive_poll(32'd0, 32'h0000_0001, 1'b0, 1'b0);
        drive_poll(32'd1, 32'hFFFF_FFF0, 1'b0, 1'b0);
        drive_poll(32'd1, 32'hFFFF_FF00, 1'b0, 1'b1);
        drive_poll(32'd2, 32'hFFFF_FE00, 1'b1, 1'b1);
        drive_poll(32'd2, 32'hFFFF_FE00 - 32'd1740, 1'b0, 1'b1);
        drive_poll(32'd30, 32'h8000_0000, 1'b0, 1'b1);
        drive_poll(32'd30, 32'h7000_0000, 1'b0, 1'b0);
        drive_poll(32'd31, 32'h6000_0000, 1'b1, 1'b0);
        drive_poll(32'd62, 32'h0000_0000, 1'b0, 1'b0);
        drive_poll(32'd62, 32'hFFFF_FFF0, 1'b0, 1'b0);
        drive_poll(32'd63, 32'hFFFF_FF00, 1'b0, 1'b0);
        drive_poll(32'd63, 32'hFFFF_FE00, 1'b1, 1'b0);
        drive_poll(32'd64, 32'h0000_0000, 1'b0, 1'b0);
        drive_poll(32'd91, 32'h5555_5555, 1'b0, 1'b0);
        drive_poll(32'd91, 32'h2AAA_AAAA, 1'b0, 1'b0);
        drive_poll(32'd92, 32'h2AAA_AA00, 1'b0, 1'b1);
        drive_poll(32'd92, 32'h2AAA_AA00 - 32'd90003, 1'b0, 1'b1);
        drive_poll(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1);
        drive_poll(32'hFFFF_FFFF, 32'hFFFF_FF00, 1'b1, 1'b1);
        drive_poll(32'hFFFF_FFFF, 32'hFFFF_FE00, 1'b1, 1'b1);
        drive_poll(32'hFFFF_FFFF, 32'hFFFF_FD00, 1'b0, 1'b1);
        drive_poll(32'd0, 32'd0, 1'b0, 1'b0);

        for (int unsigned k = 0; k < N_PHASES; k++) begin
            // drain, then retune only while the sequencer sits idle
            poll_valid <= 1'b0;
            @(negedge i_clk);
            while (sb.pending.size() != 0) @(negedge i_clk);
            if (k != 0) apply_settings(k);

            case (k % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 88; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 88; end
                default: begin send_idle_pct = 8; recv_stall_pct = 8; end
            endcase

            for (int unsigned n = 0; n < PHASE_POLLS; n++) begin
                hold_poll(n == PHASE_POLLS / 3 || $urandom_range(0, 99) == 0);
                random_poll();
            end
        end

        // wait out every outstanding result, then the longest latency
        poll_valid <= 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (80) @(posedge i_clk);

        $display("Covered %0d polls over %0d register settings and four idling patterns,",
                 sb.polls, N_PHASES);
        $display("with %0d measurements (%0d saturated), %0d timeouts, %0d register writes.",
                 sb.n_meas, sb.n_sat, sb.n_tout, sb.writes);
        if (sb.pending.size() != 0) begin
            $display("%0t: %0d predicted results never arrived", $time, sb.pending.size());
        end
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/urs_pkg.sv
rtl/urs_div.sv
rtl/urs_dp.sv
rtl/urs_ctrl.sv
rtl/ultrasonic_ranging_sequencer.sv
rtl/urs_chk.sv
tb/ultrasonic_ranging_sequencer_test.sv
